/* rtl/tbdg_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tbdg_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned DelayW = 16;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PREV   = 3'd1,
    ACT_NEXT   = 3'd2,
    ACT_REDRAW = 3'd3,
    ACT_PLAY   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_LONG     = 2'd1,
    CFG_COALESCE = 2'd2
  } cfg_idx_e;

  localparam logic [DelayW-1:0] DebounceRst = 16'd30;
  localparam logic [DelayW-1:0] LongRst     = 16'd1000;
  localparam logic [DelayW-1:0] CoalesceRst = 16'd300;

  // Debounce outcome for one button after the current sample
  typedef struct packed {
    logic press;
    logic lift;
    logic stable;
  } deb_evt_t;

  // Wrap-safe: difference must be non-negative as signed 32 bit and >= delay
  function automatic logic time_reached(logic [TimeW-1:0]  now,
                                        logic [TimeW-1:0]  since,
                                        logic [DelayW-1:0] delay);
    logic [TimeW-1:0] diff;
    diff = now - since;
    return !diff[TimeW-1] && (diff >= {{(TimeW-DelayW){1'b0}}, delay});
  endfunction

endpackage

`default_nettype wire

/* rtl/tbdg_debounce.sv */
`timescale 1ns / 1ps
`default_nettype none

module tbdg_debounce
  import tbdg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [TimeW-1:0]  now_i,
  input  wire logic              level_i,
  input  wire logic [DelayW-1:0] delay_i,
  output deb_evt_t               evt_o
);

  logic             raw_q;
  logic             stable_q;
  logic [TimeW-1:0] change_q;
  logic             changed;
  logic             settle;

  assign changed = level_i != raw_q;
  assign settle  = !changed && (raw_q != stable_q) && time_reached(now_i, change_q, delay_i);

  assign evt_o.press  = settle && raw_q;
  assign evt_o.lift   = settle && !raw_q;
  assign evt_o.stable = settle ? raw_q : stable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      change_q <= '0;
    end else if (en_i) begin
      if (changed) begin
        raw_q    <= level_i;
        change_q <= now_i;
      end else if (settle) begin
        stable_q <= raw_q;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/three_button_debounce_gesture_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// Debounce and gesture decoder for three buttons (previous, next, green).
// Input channel: one transfer per timestamp sample, carrying now_time_i and
// the three raw levels. Output channel: exactly one result per input sample,
// in order: action_o (none, previous, next, forced redraw, play/pause) and
// refresh_now_o, set when the coalesced refresh deadline has been reached.
// An accepted sample is captured in the input register and its result is then
// registered in the output register. Throughput is one sample per cycle while
// the receiver is ready: the sample sits in an input register, the decode is a
// single pass of 32-bit subtracts and compares, and the result lands in an
// output register; the button state is updated as the result is registered.
// When the receiver stalls, the result is held and one further sample waits
// in the input register; in_ready_o drops only when both are occupied.
// Configuration: cfg_index_i 0 debounce delay, 1 long-press delay,
// 2 coalesce delay, 16-bit ms values; other indices are ignored. cfg_ready_o
// is always high; write only while no sample is in flight.
// Reset clears all button state and restores delays of 30, 1000 and 300 ms.
module three_button_debounce_gesture_top
  import tbdg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [TimeW-1:0]  now_time_i,
  input  wire logic              previous_level_i,
  input  wire logic              next_level_i,
  input  wire logic              green_level_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [2:0]             action_o,
  output logic                   refresh_now_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [DelayW-1:0] cfg_data_i
);

  logic [DelayW-1:0] debounce_q, long_q, coalesce_q;

  logic             in_vld_q;
  logic [TimeW-1:0] now_q;
  logic             prev_q, next_q, green_q;

  logic             out_vld_q;
  action_e          action_q, action_d;
  logic             refresh_q, refresh_d;

  logic             gpress_q, gpress_d;
  logic [TimeW-1:0] gtime_q, gtime_d;
  logic             fired_q, fired_d;
  logic             pend_q, pend_d;
  logic [TimeW-1:0] due_q, due_d;

  logic     adv;
  logic     en_prev, en_next, en_green;
  deb_evt_t ev_prev, ev_next, ev_green;
  logic     fire_long;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      long_q     <= LongRst;
      coalesce_q <= CoalesceRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_LONG:     long_q     <= cfg_data_i;
        CFG_COALESCE: coalesce_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register advances into the output register whenever that is free
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      now_q   <= now_time_i;
      prev_q  <= previous_level_i;
      next_q  <= next_level_i;
      green_q <= green_level_i;
    end
  end

  // A settled press of an earlier button leaves later buttons untouched
  assign en_prev  = adv;
  assign en_next  = adv && !ev_prev.press;
  assign en_green = adv && !ev_prev.press && !ev_next.press;

  tbdg_debounce u_deb_prev (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_prev),
    .now_i   (now_q),
    .level_i (prev_q),
    .delay_i (debounce_q),
    .evt_o   (ev_prev)
  );

  tbdg_debounce u_deb_next (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_next),
    .now_i   (now_q),
    .level_i (next_q),
    .delay_i (debounce_q),
    .evt_o   (ev_next)
  );

  tbdg_debounce u_deb_green (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_green),
    .now_i   (now_q),
    .level_i (green_q),
    .delay_i (debounce_q),
    .evt_o   (ev_green)
  );

  always_comb begin
    gpress_d  = gpress_q;
    gtime_d   = ev_green.press ? now_q : gtime_q;
    fired_d   = ev_green.press ? 1'b0 : fired_q;
    fire_long = ev_green.stable && !fired_d && time_reached(now_q, gtime_d, long_q);
    action_d  = ACT_NONE;
    if (ev_prev.press) begin
      action_d = ACT_PREV;
    end else if (ev_next.press) begin
      action_d = ACT_NEXT;
    end else if (fire_long) begin
      action_d = ACT_REDRAW;
      fired_d  = 1'b1;
    end else if (ev_green.lift && !fired_d) begin
      action_d = ACT_PLAY;
    end
    gpress_d = ev_green.stable;

    pend_q_mux: begin
      pend_d = pend_q;
      due_d  = due_q;
      if (action_d != ACT_NONE) begin
        pend_d = 1'b1;
        due_d  = now_q + {{(TimeW-DelayW){1'b0}}, coalesce_q};
      end
      // Deadline reached: difference is non-negative as a signed value
      refresh_d = pend_d && time_reached(now_q, due_d, '0);
      if (refresh_d) begin
        pend_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpress_q <= 1'b0;
      gtime_q  <= '0;
      fired_q  <= 1'b0;
    end else if (en_green) begin
      gpress_q <= gpress_d;
      gtime_q  <= gtime_d;
      fired_q  <= fired_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      due_q  <= '0;
    end else if (adv) begin
      pend_q <= pend_d;
      due_q  <= due_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      action_q  <= action_d;
      refresh_q <= refresh_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign action_o      = action_q;
  assign refresh_now_o = refresh_q;

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a blocked result");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("advanced sample produced no result");

  a_long_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_green && fire_long) |=> (fired_q && gpress_q))
    else $error("long press not recorded");

  a_refresh_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && refresh_d) |=> (!pend_q && refresh_q))
    else $error("refresh reported but still pending");

  a_early_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && ev_prev.press) |-> (!en_next && !en_green && action_d == ACT_PREV))
    else $error("later buttons examined after previous press");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench
  import tbdg_pkg::*;
();

  localparam int BtnPrev  = 0;
  localparam int BtnNext  = 1;
  localparam int BtnGreen = 2;
  localparam logic [1:0] CfgSpare = 2'd3;  // unmapped register index

  typedef enum logic [1:0] {
    SETTLE_NONE,
    SETTLE_PRESS,
    SETTLE_LIFT
  } settle_e;

  typedef struct packed {
    logic [TimeW-1:0] stamp;
    logic             prev_lvl;
    logic             next_lvl;
    logic             green_lvl;
  } sample_t;

  typedef struct packed {
    action_e action;
    logic    refresh;
  } gesture_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [TimeW-1:0]  now_time_i = '0;
  logic              previous_level_i = 1'b0;
  logic              next_level_i = 1'b0;
  logic              green_level_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [2:0]        action_o;
  logic              refresh_now_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [DelayW-1:0] cfg_data_i = '0;

  three_button_debounce_gesture_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .now_time_i       (now_time_i),
    .previous_level_i (previous_level_i),
    .next_level_i     (next_level_i),
    .green_level_i    (green_level_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .action_o         (action_o),
    .refresh_now_o    (refresh_now_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Predictor copy of the delays and button state
  logic [DelayW-1:0] dly_debounce = DebounceRst;
  logic [DelayW-1:0] dly_long     = LongRst;
  logic [DelayW-1:0] dly_coalesce = CoalesceRst;
  logic              raw_lvl [3] = '{3{1'b0}};
  logic              stable_lvl [3] = '{3{1'b0}};
  logic [TimeW-1:0]  change_t [3] = '{3{32'h0}};
  logic [TimeW-1:0]  green_press_t = '0;
  logic              redraw_done = 1'b0;
  logic              refresh_pend = 1'b0;
  logic [TimeW-1:0]  refresh_due_t = '0;

  sample_t  sample_q [$];
  gesture_t gesture_q [$];
  sample_t  drv_pick;
  gesture_t want;
  int       fail_count = 0;
  int       idle_in_pct = 0;
  int       stall_out_pct = 0;

  // Stimulus generator state
  logic [TimeW-1:0] clock_ms;
  logic             lvl_p = 1'b0;
  logic             lvl_n = 1'b0;
  logic             lvl_g = 1'b0;

  // Wrap-safe elapsed test: forward distance below 2^31 and at least the delay
  function automatic logic held_for(input logic [TimeW-1:0] now, input logic [TimeW-1:0] since,
                                    input logic [DelayW-1:0] delay);
    logic [TimeW-1:0] gap;
    gap = now - since;
    return (gap < 32'h8000_0000) && (gap >= {16'h0, delay});
  endfunction

  function automatic settle_e debounce_step(input int b, input logic lvl,
                                            input logic [TimeW-1:0] now);
    if (lvl != raw_lvl[b]) begin
      raw_lvl[b] = lvl;
      change_t[b] = now;
      return SETTLE_NONE;
    end
    if (raw_lvl[b] == stable_lvl[b]) return SETTLE_NONE;
    if (!held_for(now, change_t[b], dly_debounce)) return SETTLE_NONE;
    stable_lvl[b] = raw_lvl[b];
    return stable_lvl[b] ? SETTLE_PRESS : SETTLE_LIFT;
  endfunction

  function automatic void arm_refresh(input logic [TimeW-1:0] now);
    refresh_pend = 1'b1;
    refresh_due_t = now + {16'h0, dly_coalesce};
  endfunction

  function automatic gesture_t decode_sample(input logic [TimeW-1:0] now, input logic p,
                                             input logic n, input logic g);
    gesture_t r;
    settle_e  gs;
    r.action = ACT_NONE;
    r.refresh = 1'b0;
    // previous and next short-circuit: later buttons untouched on a settled press
    if (debounce_step(BtnPrev, p, now) == SETTLE_PRESS) begin
      arm_refresh(now);
      r.action = ACT_PREV;
    end else if (debounce_step(BtnNext, n, now) == SETTLE_PRESS) begin
      arm_refresh(now);
      r.action = ACT_NEXT;
    end else begin
      gs = debounce_step(BtnGreen, g, now);
      if (gs == SETTLE_PRESS) begin
        green_press_t = now;
        redraw_done = 1'b0;
      end
      if (stable_lvl[BtnGreen] && !redraw_done && held_for(now, green_press_t, dly_long)) begin
        redraw_done = 1'b1;
        arm_refresh(now);
        r.action = ACT_REDRAW;
      end else if (gs == SETTLE_LIFT && !redraw_done) begin
        arm_refresh(now);
        r.action = ACT_PLAY;
      end
    end
    if (refresh_pend && held_for(now, refresh_due_t, 16'h0)) begin
      refresh_pend = 1'b0;
      r.refresh = 1'b1;
    end
    return r;
  endfunction

  // Sample driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        gesture_q.push_back(decode_sample(now_time_i, previous_level_i, next_level_i,
                                          green_level_i));
      if (!in_valid_i || in_ready_o) begin
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= idle_in_pct) begin
          drv_pick = sample_q.pop_front();
          in_valid_i       <= 1'b1;
          now_time_i       <= drv_pick.stamp;
          previous_level_i <= drv_pick.prev_lvl;
          next_level_i     <= drv_pick.next_lvl;
          green_level_i    <= drv_pick.green_lvl;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (gesture_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got action %0d refresh %0b",
                   $time, action_o, refresh_now_o);
          fail_count++;
        end else begin
          want = gesture_q.pop_front();
          if (action_o !== want.action) begin
            $display("%0t: action expected %0d got %0d", $time, want.action, action_o);
            fail_count++;
          end
          if (refresh_now_o !== want.refresh) begin
            $display("%0t: refresh_now expected %0b got %0b", $time, want.refresh,
                     refresh_now_o);
            fail_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= stall_out_pct);
    end
  end

  task automatic add_sample(input logic [TimeW-1:0] t, input logic p, input logic n,
                            input logic g);
    sample_t s;
    s.stamp = t;
    s.prev_lvl = p;
    s.next_lvl = n;
    s.green_lvl = g;
    sample_q.push_back(s);
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid_i || gesture_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the caller drops it after the last transfer
  task automatic write_reg(input logic [1:0] idx, input logic [DelayW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_DEBOUNCE: dly_debounce = val;
      CFG_LONG:     dly_long = val;
      CFG_COALESCE: dly_coalesce = val;
      default: ;
    endcase
  endtask

  task automatic set_delays(input logic [DelayW-1:0] deb, input logic [DelayW-1:0] lng,
                            input logic [DelayW-1:0] coal);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_LONG, lng);
    write_reg(CFG_COALESCE, coal);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly held levels with occasional toggles so presses settle and long holds occur
  task automatic run_gestures(input int count);
    int unsigned step_max;
    int unsigned roll;
    step_max = dly_long / 4 + dly_debounce + 8;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        clock_ms = $urandom;
        lvl_p = 1'($urandom_range(0, 1));
        lvl_n = 1'($urandom_range(0, 1));
        lvl_g = 1'($urandom_range(0, 1));
      end else begin
        if (roll < 11) lvl_p = !lvl_p;
        else if (roll < 19) lvl_n = !lvl_n;
        else if (roll < 29) lvl_g = !lvl_g;
        if (roll >= 95) clock_ms += $urandom_range(0, 3);  // contact bounce
        else clock_ms += $urandom_range(0, step_max);
      end
      add_sample(clock_ms, lvl_p, lvl_n, lvl_g);
    end
  endtask

  initial begin
    logic [TimeW-1:0] b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, reset delays; timeline crosses the 2^32 wrap
    b = 32'hFFFF_FE00;
    add_sample(b,        1'b0, 1'b0, 1'b0);
    add_sample(b + 10,   1'b1, 1'b1, 1'b0);
    add_sample(b + 45,   1'b1, 1'b1, 1'b1);  // previous settles, rest skipped
    add_sample(b + 50,   1'b1, 1'b1, 1'b1);  // next settles
    add_sample(b + 55,   1'b1, 1'b1, 1'b1);
    add_sample(b + 90,   1'b1, 1'b1, 1'b1);  // green settles down
    add_sample(b + 400,  1'b0, 1'b0, 1'b1);
    add_sample(b + 440,  1'b0, 1'b0, 1'b1);
    add_sample(b + 1090, 1'b0, 1'b0, 1'b1);  // long press
    add_sample(b + 1200, 1'b0, 1'b0, 1'b0);
    add_sample(b + 1235, 1'b0, 1'b0, 1'b0);  // release after long press
    add_sample(b + 1400, 1'b0, 1'b0, 1'b0);
    add_sample(b + 1500, 1'b0, 1'b0, 1'b1);
    add_sample(b + 1510, 1'b0, 1'b0, 1'b0);
    add_sample(b + 1520, 1'b0, 1'b0, 1'b1);
    add_sample(b + 1560, 1'b0, 1'b0, 1'b1);
    add_sample(b + 1600, 1'b0, 1'b0, 1'b0);
    add_sample(b + 1640, 1'b0, 1'b0, 1'b0);  // short release
    b = b + 1640 + 32'h9000_0000;
    add_sample(b,        1'b1, 1'b0, 1'b0);
    add_sample(b - 5,    1'b1, 1'b0, 1'b0);  // stamp behind change time
    add_sample(b + 40,   1'b1, 1'b0, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
    wait_idle();

    // Zero delays: press settles and fires in one sample, refresh in the same step
    write_reg(CfgSpare, 16'hFFFF);
    set_delays(16'h0, 16'h0, 16'h0);
    clock_ms = 32'h7FFF_FFF0;
    add_sample(clock_ms,      1'b0, 1'b0, 1'b1);
    add_sample(clock_ms,      1'b0, 1'b0, 1'b1);
    add_sample(clock_ms + 1,  1'b0, 1'b0, 1'b0);
    add_sample(clock_ms + 1,  1'b0, 1'b0, 1'b0);
    add_sample(clock_ms + 20, 1'b0, 1'b1, 1'b0);
    add_sample(clock_ms + 20, 1'b0, 1'b1, 1'b0);
    wait_idle();

    idle_in_pct = 0;
    stall_out_pct = 0;
    set_delays(DebounceRst, LongRst, CoalesceRst);
    lvl_p = 1'b0;
    lvl_n = 1'b1;
    lvl_g = 1'b0;
    run_gestures(200);
    wait_idle();  // sender holds off until the pipeline drains
    run_gestures(250);
    wait_idle();

    idle_in_pct = 84;
    set_delays(16'h0, 16'h0, 16'h0);
    run_gestures(350);
    wait_idle();

    idle_in_pct = 0;
    stall_out_pct = 84;
    set_delays(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_gestures(350);
    wait_idle();

    idle_in_pct = 11;
    stall_out_pct = 11;
    set_delays(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
               16'($urandom_range(0, 65535)));
    run_gestures(400);
    wait_idle();

    idle_in_pct = 0;
    stall_out_pct = 0;
    set_delays(16'($urandom_range(1, 50)), 16'($urandom_range(100, 2000)),
               16'($urandom_range(1, 400)));
    run_gestures(400);
    wait_idle();

    repeat (10) @(posedge clk_i);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
